/* rtl/rpc_pkg.sv */
// ----------------------------------------------------------------------------
// rpc_pkg
// Shared types, constants and the quarter-wave sine table for the point
// rotation block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rpc_pkg;

  // angle and trig formats
  localparam int ANGLE_BITS     = 16;
  localparam int TRIG_FRAC_BITS = 15;
  localparam int OUT_ANGLE_W    = 16;
  localparam int TAB_ADDR_BITS  = 10;
  localparam int QSTEPS         = 256;
  localparam int QIDX_W         = 9;

  // coordinate widths
  localparam int X_W    = 10;
  localparam int Y_W    = 9;
  localparam int DMAG_W = 10;
  localparam int PROD_W = DMAG_W + TRIG_FRAC_BITS;
  localparam int SUM_W  = 13;
  localparam int OUT_W  = 12;
  localparam int STEP_W = 16;

  // multiplier digit size per cell and number of cells in the row
  localparam int DIGIT_W   = 3;
  localparam int NUM_CELLS = (TRIG_FRAC_BITS + DIGIT_W - 1) / DIGIT_W;

  // register file
  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;

  localparam logic [X_W-1:0]    CENTRE_X_RST   = X_W'(320);
  localparam logic [Y_W-1:0]    CENTRE_Y_RST   = Y_W'(240);
  localparam logic [X_W-1:0]    POINT_X_RST    = X_W'(400);
  localparam logic [Y_W-1:0]    POINT_Y_RST    = Y_W'(240);
  localparam logic [STEP_W-1:0] ANGLE_STEP_RST = STEP_W'(522);

  localparam logic signed [SUM_W-1:0] OUT_MIN = -SUM_W'(2048);
  localparam logic signed [SUM_W-1:0] OUT_MAX = SUM_W'(2047);

  typedef enum logic [2:0] {
    REG_CENTRE_X   = 3'd0,
    REG_CENTRE_Y   = 3'd1,
    REG_POINT_X    = 3'd2,
    REG_POINT_Y    = 3'd3,
    REG_ANGLE_STEP = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [X_W-1:0]    centre_x;
    logic [Y_W-1:0]    centre_y;
    logic [X_W-1:0]    point_x;
    logic [Y_W-1:0]    point_y;
    logic [STEP_W-1:0] angle_step;
  } cfg_t;

  // data carried along the row of multiply cells
  typedef struct packed {
    logic [PROD_W-1:0]         dx_sh;
    logic [PROD_W-1:0]         dy_sh;
    logic [TRIG_FRAC_BITS-1:0] sin_m;
    logic [TRIG_FRAC_BITS-1:0] cos_m;
    logic [PROD_W-1:0]         acc_xc;
    logic [PROD_W-1:0]         acc_ys;
    logic [PROD_W-1:0]         acc_xs;
    logic [PROD_W-1:0]         acc_yc;
    logic                      neg_xc;
    logic                      neg_ys;
    logic                      neg_xs;
    logic                      neg_yc;
    logic [X_W-1:0]            centre_x;
    logic [Y_W-1:0]            centre_y;
    logic [OUT_ANGLE_W-1:0]    angle;
  } cell_data_t;

  typedef logic [TRIG_FRAC_BITS-1:0] trig_mag_t;
  typedef trig_mag_t qw_table_t [0:QSTEPS];

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // q30 product, truncated
  function automatic logic [63:0] mul_q30(input logic [63:0] a, input logic [63:0] b);
    return (a * b) >> 30;
  endfunction

  // taylor series sine of k quarter-turn steps, rounded to trig format
  function automatic trig_mag_t sine_entry(input int unsigned k);
    logic [63:0]        x;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic signed [63:0] r;
    x    = (64'(k) * HALF_PI_Q30) >> 8;
    sum  = $signed(x);
    term = x;
    term = mul_q30(mul_q30(term, x), x) / 64'd6;
    sum  = sum - $signed(term);
    term = mul_q30(mul_q30(term, x), x) / 64'd20;
    sum  = sum + $signed(term);
    term = mul_q30(mul_q30(term, x), x) / 64'd42;
    sum  = sum - $signed(term);
    term = mul_q30(mul_q30(term, x), x) / 64'd72;
    sum  = sum + $signed(term);
    term = mul_q30(mul_q30(term, x), x) / 64'd110;
    sum  = sum - $signed(term);
    term = mul_q30(mul_q30(term, x), x) / 64'd156;
    sum  = sum + $signed(term);
    term = mul_q30(mul_q30(term, x), x) / 64'd210;
    sum  = sum - $signed(term);
    term = mul_q30(mul_q30(term, x), x) / 64'd272;
    sum  = sum + $signed(term);
    if (sum < 64'sd0) begin
      sum = 64'sd0;
    end
    r = (sum + (64'sd1 <<< (29 - TRIG_FRAC_BITS))) >>> (30 - TRIG_FRAC_BITS);
    if (r > ((64'sd1 <<< TRIG_FRAC_BITS) - 64'sd1)) begin
      r = (64'sd1 <<< TRIG_FRAC_BITS) - 64'sd1;
    end
    return TRIG_FRAC_BITS'(r);
  endfunction

  function automatic qw_table_t build_qw();
    qw_table_t t;
    for (int k = 0; k <= QSTEPS; k++) begin
      t[k] = sine_entry(k);
    end
    return t;
  endfunction

  localparam qw_table_t QW_TABLE = build_qw();

endpackage

`default_nettype wire

/* rtl/rpc_cfg.sv */
// ----------------------------------------------------------------------------
// rpc_cfg
// APB register file holding the pivot, the point and the angle step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rpc_cfg
  import rpc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready,
  output cfg_t                       cfg
);

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite && pready;
  assign cfg    = cfg_r;

  // register writes, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.centre_x   <= CENTRE_X_RST;
      cfg_r.centre_y   <= CENTRE_Y_RST;
      cfg_r.point_x    <= POINT_X_RST;
      cfg_r.point_y    <= POINT_Y_RST;
      cfg_r.angle_step <= ANGLE_STEP_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_CENTRE_X:   cfg_r.centre_x   <= pwdata[X_W-1:0];
        REG_CENTRE_Y:   cfg_r.centre_y   <= pwdata[Y_W-1:0];
        REG_POINT_X:    cfg_r.point_x    <= pwdata[X_W-1:0];
        REG_POINT_Y:    cfg_r.point_y    <= pwdata[Y_W-1:0];
        REG_ANGLE_STEP: cfg_r.angle_step <= pwdata[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (idx)
      REG_CENTRE_X:   prdata = APB_DATA_W'(cfg_r.centre_x);
      REG_CENTRE_Y:   prdata = APB_DATA_W'(cfg_r.centre_y);
      REG_POINT_X:    prdata = APB_DATA_W'(cfg_r.point_x);
      REG_POINT_Y:    prdata = APB_DATA_W'(cfg_r.point_y);
      REG_ANGLE_STEP: prdata = APB_DATA_W'(cfg_r.angle_step);
      default:        prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

/* rtl/rpc_cell.sv */
// ----------------------------------------------------------------------------
// rpc_cell
// One cell of the shift-add multiplier row: adds one multiplier digit's
// partial products to the four running products and hands them on.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rpc_cell
  import rpc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       up_valid,
  input  cell_data_t      up_data,
  output logic            up_ready,
  output logic            dn_valid,
  output cell_data_t      dn_data,
  input  wire logic       dn_ready
);

  logic       valid_r;
  cell_data_t data_r;
  cell_data_t data_nxt;
  logic [PROD_W-1:0] sin_d;
  logic [PROD_W-1:0] cos_d;

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  assign sin_d = PROD_W'(up_data.sin_m[DIGIT_W-1:0]);
  assign cos_d = PROD_W'(up_data.cos_m[DIGIT_W-1:0]);

  // accumulate low digit, then shift multiplicands up and multipliers down
  always_comb begin
    data_nxt        = up_data;
    data_nxt.acc_xc = up_data.acc_xc + up_data.dx_sh * cos_d;
    data_nxt.acc_ys = up_data.acc_ys + up_data.dy_sh * sin_d;
    data_nxt.acc_xs = up_data.acc_xs + up_data.dx_sh * sin_d;
    data_nxt.acc_yc = up_data.acc_yc + up_data.dy_sh * cos_d;
    data_nxt.dx_sh  = up_data.dx_sh << DIGIT_W;
    data_nxt.dy_sh  = up_data.dy_sh << DIGIT_W;
    data_nxt.sin_m  = up_data.sin_m >> DIGIT_W;
    data_nxt.cos_m  = up_data.cos_m >> DIGIT_W;
  end

  // stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/point_rotation_about_centre.sv */
// ----------------------------------------------------------------------------
// point_rotation_about_centre
// Rotates a configured point anticlockwise about a configured centre by
// a binary angle that advances by a configured step on ticks with advance set.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_stall carries one tick item (in_advance). With advance set
//   the angle accumulator first adds angle_step, modulo one full turn.
//   out_valid/out_stall returns one result item per tick: the rotated
//   x and y, saturated to 12-bit two's complement, and the angle used.
//   The user must write the registers (centre, point, step) over the APB
//   port only while no item is in flight; the block does not enforce it.
//   pready is always high. The angle update and sine/cosine lookup are
//   loaded into the front register when an input is accepted; the item then
//   passes through the row of five shift-add multiply cells (3 multiplier
//   bits each), and the final sum and saturation go into the output register.
//   Throughput is one item per cycle while out_stall is low; every stage
//   has its own valid and moves whenever the next stage is empty or moving.
//   When the receiver stalls, the pipeline fills and holds up to seven
//   items before in_stall rises; nothing is dropped.
//   Reset clears the angle to zero, restores the register defaults and
//   empties the pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module point_rotation_about_centre
  import rpc_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic                    in_advance,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic signed [OUT_W-1:0]      out_rotated_x,
  output logic signed [OUT_W-1:0]      out_rotated_y,
  output logic [OUT_ANGLE_W-1:0]       out_current_angle,
  input  wire logic                    psel,
  input  wire logic                    penable,
  input  wire logic                    pwrite,
  input  wire logic [APB_ADDR_W-1:0]   paddr,
  input  wire logic [APB_DATA_W-1:0]   pwdata,
  output logic      [APB_DATA_W-1:0]   prdata,
  output logic                         pready
);

  cfg_t cfg;

  logic [ANGLE_BITS-1:0] angle_r;
  logic [ANGLE_BITS-1:0] angle_nxt;
  logic                  in_accept;

  logic [TAB_ADDR_BITS-1:0] sin_idx;
  logic [TAB_ADDR_BITS-1:0] cos_idx;
  trig_mag_t                sin_mag;
  trig_mag_t                cos_mag;
  logic                     sin_neg;
  logic                     cos_neg;

  logic signed [X_W:0] dx;
  logic signed [X_W:0] dy;
  logic [DMAG_W-1:0]   dx_mag;
  logic [DMAG_W-1:0]   dy_mag;
  logic                dx_neg;
  logic                dy_neg;

  cell_data_t s0_nxt;
  logic       s0_valid_r;
  cell_data_t s0_data_r;
  logic       s0_ready;

  logic       link_valid [0:NUM_CELLS];
  cell_data_t link_data  [0:NUM_CELLS];
  logic       link_ready [0:NUM_CELLS];

  cell_data_t               fin;
  logic signed [SUM_W-1:0]  t_xc;
  logic signed [SUM_W-1:0]  t_ys;
  logic signed [SUM_W-1:0]  t_xs;
  logic signed [SUM_W-1:0]  t_yc;
  logic signed [SUM_W-1:0]  rx_sum;
  logic signed [SUM_W-1:0]  ry_sum;
  logic                     out_ready;
  logic                     out_valid_r;
  logic signed [OUT_W-1:0]  rx_r;
  logic signed [OUT_W-1:0]  ry_r;
  logic [OUT_ANGLE_W-1:0]   ang_r;

  // sine magnitude for a table address
  function automatic trig_mag_t qw_mag(input logic [TAB_ADDR_BITS-1:0] idx);
    logic [QIDX_W-1:0] f;
    f = {1'b0, idx[TAB_ADDR_BITS-3:0]};
    if (idx[TAB_ADDR_BITS-2]) begin
      return QW_TABLE[QIDX_W'(QSTEPS) - f];
    end
    return QW_TABLE[f];
  endfunction

  // signed term from a product magnitude
  function automatic logic signed [SUM_W-1:0] term(input logic [PROD_W-1:0] acc,
                                                   input logic neg);
    logic signed [SUM_W-1:0] m;
    m = SUM_W'(acc[PROD_W-1 -: DMAG_W]);
    return neg ? -m : m;
  endfunction

  function automatic logic signed [OUT_W-1:0] sat(input logic signed [SUM_W-1:0] v);
    if (v < OUT_MIN) begin
      return OUT_W'(OUT_MIN);
    end
    if (v > OUT_MAX) begin
      return OUT_W'(OUT_MAX);
    end
    return OUT_W'(v);
  endfunction

  rpc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // input handshake
  assign s0_ready  = !s0_valid_r || link_ready[0];
  assign in_stall  = !s0_ready;
  assign in_accept = in_valid && s0_ready;

  // angle accumulator
  always_comb begin
    angle_nxt = angle_r;
    if (in_advance) begin
      angle_nxt = angle_r + ANGLE_BITS'(cfg.angle_step);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angle_r <= '0;
    end else if (in_accept) begin
      angle_r <= angle_nxt;
    end
  end

  // sine and cosine lookup
  assign sin_idx = angle_nxt[ANGLE_BITS-1 -: TAB_ADDR_BITS];
  assign cos_idx = sin_idx + TAB_ADDR_BITS'(QSTEPS);
  assign sin_mag = qw_mag(sin_idx);
  assign cos_mag = qw_mag(cos_idx);
  assign sin_neg = sin_idx[TAB_ADDR_BITS-1];
  assign cos_neg = cos_idx[TAB_ADDR_BITS-1];

  // offsets from the centre as sign and magnitude
  assign dx     = $signed({1'b0, cfg.point_x}) - $signed({1'b0, cfg.centre_x});
  assign dy     = $signed(X_W'(cfg.point_y)) - $signed(X_W'(cfg.centre_y));
  assign dx_neg = dx[X_W];
  assign dy_neg = dy[X_W];
  assign dx_mag = dx_neg ? DMAG_W'(-dx) : DMAG_W'(dx);
  assign dy_mag = dy_neg ? DMAG_W'(-dy) : DMAG_W'(dy);

  always_comb begin
    s0_nxt          = '0;
    s0_nxt.dx_sh    = PROD_W'(dx_mag);
    s0_nxt.dy_sh    = PROD_W'(dy_mag);
    s0_nxt.sin_m    = sin_mag;
    s0_nxt.cos_m    = cos_mag;
    s0_nxt.neg_xc   = dx_neg ^ cos_neg;
    s0_nxt.neg_ys   = dy_neg ^ sin_neg;
    s0_nxt.neg_xs   = dx_neg ^ sin_neg;
    s0_nxt.neg_yc   = dy_neg ^ cos_neg;
    s0_nxt.centre_x = cfg.centre_x;
    s0_nxt.centre_y = cfg.centre_y;
    s0_nxt.angle    = OUT_ANGLE_W'(angle_nxt);
  end

  // front stage register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (s0_ready) begin
      s0_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s0_data_r <= s0_nxt;
    end
  end

  assign link_valid[0] = s0_valid_r;
  assign link_data[0]  = s0_data_r;

  // row of multiply cells
  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    rpc_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (link_valid[i]),
      .up_data  (link_data[i]),
      .up_ready (link_ready[i]),
      .dn_valid (link_valid[i+1]),
      .dn_data  (link_data[i+1]),
      .dn_ready (link_ready[i+1])
    );
  end

  // final sums and saturation
  assign fin    = link_data[NUM_CELLS];
  assign t_xc   = term(fin.acc_xc, fin.neg_xc);
  assign t_ys   = term(fin.acc_ys, fin.neg_ys);
  assign t_xs   = term(fin.acc_xs, fin.neg_xs);
  assign t_yc   = term(fin.acc_yc, fin.neg_yc);
  assign rx_sum = SUM_W'(fin.centre_x) + t_xc - t_ys;
  assign ry_sum = SUM_W'(fin.centre_y) + t_xs + t_yc;

  // output register
  assign out_ready             = !out_valid_r || !out_stall;
  assign link_ready[NUM_CELLS] = out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ready) begin
      out_valid_r <= link_valid[NUM_CELLS];
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && link_valid[NUM_CELLS]) begin
      rx_r  <= sat(rx_sum);
      ry_r  <= sat(ry_sum);
      ang_r <= fin.angle;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_rotated_x     = rx_r;
  assign out_rotated_y     = ry_r;
  assign out_current_angle = ang_r;

endmodule

`default_nettype wire
